[rtl/core/acfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfr_pkg: shared types and constants of the framed byte receiver
// Beat structs, verdict codes, framing bytes and the ASCII hex encoder.
// ----------------------------------------------------------------------------
package acfr_pkg;

   localparam logic [7:0] START_BYTE = 8'h02;
   localparam logic [7:0] TAIL_BYTE  = 8'h03;
   localparam logic [7:0] BROADCAST  = 8'hFF;
   localparam logic [7:0] MIN_LENGTH = 8'd8;
   localparam logic [7:0] OWN_ADDRESS_RESET = 8'd1;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_CHECKSUM  = 3'd1,
      ST_BAD_TAIL  = 3'd2,
      ST_ADDRESS   = 3'd3,
      ST_TOO_SHORT = 3'd4,
      ST_TRUNCATED = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [7:0] command;
      logic [7:0] frame_type;
      logic [7:0] channel;
      logic [7:0] payload_length;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type payload;
   } result_type;

   // uppercase ASCII hex digit of one nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
   endfunction

endpackage

[rtl/core/ascii_checksum_frame_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_checksum_frame_receiver: framed byte receiver with hex sum check
// Hunts for STX, parses header, forwards payload, issues a frame verdict.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one received byte per beat plus an end-of-burst flag.
//   rsp_*  : a forwarded payload byte (kind 0) or a frame verdict (kind 1),
//            carrying the header fields seen so far in the frame.
//   csr_*  : write-only own_address register, always ready; write it only
//            while the block is idle.
// Frame: STX, length L, type, channel, command, L-8 payload bytes, two
//   uppercase hex chars of the 8-bit sum of bytes 1..L-4, ETX.
// Throughput: one byte per cycle while rsp_stall is low. Bytes outside a
//   frame give no beat; header/checksum bytes give one only as a verdict.
// Path: a response beat follows its accepted byte through the input
//   register, then the parser into the output register.
// Reset: synchronous; the parser hunts for STX, own_address returns to 1.
// Stall: if rsp_stall holds the output register full, the parser pauses and
//   req_stall rises once the input register is also occupied; nothing is
//   lost or reordered.
// ----------------------------------------------------------------------------
module ascii_checksum_frame_receiver (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  acfr_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output acfr_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);
   import acfr_pkg::*;

   logic [7:0] own_addr_ff, own_addr_in;
   logic       held_valid;
   req_type    held_payload;
   logic       room;
   logic       advance;
   result_type result;

   // config register, always accepting
   assign csr_ready   = 1'b1;
   assign own_addr_in = (csr_valid && csr_ready) ? csr_data : own_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff <= OWN_ADDRESS_RESET;
      end else begin
         own_addr_ff <= own_addr_in;
      end
   end

   // parser steps whenever a byte is held and the output side has room
   assign advance = held_valid && room;

   acfr_in_reg u_in_reg (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .advance      (advance),
      .held_valid   (held_valid),
      .held_payload (held_payload)
   );

   acfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (held_payload),
      .own_address (own_addr_ff),
      .result      (result)
   );

   acfr_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .result      (result),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .room        (room)
   );

`ifndef SYNTHESIS
   // input only backs up when the output register is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   // a held byte with a free output register is always consumed
   a_no_idle: assert property (@(posedge clock) disable iff (reset)
      held_valid && !rsp_valid |-> advance)
      else $error("held byte not processed while output free");

   // a stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");
`endif

endmodule

[rtl/core/acfr_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfr_in_reg: input beat register
// Captures one request beat; holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module acfr_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  acfr_pkg::req_type req_payload,
   input  logic              advance,
   output logic              held_valid,
   output acfr_pkg::req_type held_payload
);
   import acfr_pkg::*;

   logic    valid_ff, valid_in;
   req_type payload_ff, payload_in;
   logic    take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in   = valid_ff;
      payload_in = payload_ff;
      if (take) begin
         valid_in   = 1'b1;
         payload_in = req_payload;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      payload_ff <= payload_in;
   end

   assign held_valid   = valid_ff;
   assign held_payload = payload_ff;

endmodule

[rtl/core/acfr_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfr_parser: frame state machine
// Walks one byte per beat through the frame, keeps header fields and the
// running sum, and forms the forwarded byte or verdict for that beat.
// ----------------------------------------------------------------------------
module acfr_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  acfr_pkg::req_type    item,
   input  logic [7:0]           own_address,
   output acfr_pkg::result_type result
);
   import acfr_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN,
      PH_TYPE,
      PH_CHAN,
      PH_CMD,
      PH_BODY,
      PH_TAIL_GOOD,
      PH_TAIL_BAD
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] chan_ff, chan_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] hex1_ff, hex1_in;

   logic       verdict;
   status_type code;
   logic       forward;
   logic       taken;
   logic [8:0] pos_ext, len_ext;
   logic [7:0] b;

   assign b       = item.rx_byte;
   assign pos_ext = {1'b0, pos_ff};
   assign len_ext = {1'b0, len_ff};

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff + 8'd1;
      len_in   = len_ff;
      type_in  = type_ff;
      chan_in  = chan_ff;
      cmd_in   = cmd_ff;
      sum_in   = sum_ff;
      hex1_in  = hex1_ff;
      verdict  = 1'b0;
      code     = ST_OK;
      forward  = 1'b0;
      taken    = 1'b1;
      case (phase_ff)
         PH_HUNT: begin
            if (b == START_BYTE) begin
               len_in   = '0;
               type_in  = '0;
               chan_in  = '0;
               cmd_in   = '0;
               sum_in   = '0;
               hex1_in  = '0;
               phase_in = PH_LEN;
            end else begin
               taken  = 1'b0;
               pos_in = pos_ff;
            end
         end
         PH_LEN: begin
            len_in = b;
            sum_in = sum_ff + b;
            if (b < MIN_LENGTH) begin
               verdict = 1'b1;
               code    = ST_TOO_SHORT;
            end else begin
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            type_in  = b;
            sum_in   = sum_ff + b;
            phase_in = PH_CHAN;
         end
         PH_CHAN: begin
            chan_in = b;
            sum_in  = sum_ff + b;
            if (b != own_address && b != BROADCAST) begin
               verdict = 1'b1;
               code    = ST_ADDRESS;
            end else begin
               phase_in = PH_CMD;
            end
         end
         PH_CMD: begin
            cmd_in   = b;
            sum_in   = sum_ff + b;
            phase_in = PH_BODY;
         end
         PH_BODY: begin
            if (pos_ext + 9'd4 <= len_ext) begin
               sum_in  = sum_ff + b;
               forward = 1'b1;
            end else if (pos_ext + 9'd3 == len_ext) begin
               hex1_in = b;
            end else if (hex1_ff == hex_char(sum_ff[7:4]) && b == hex_char(sum_ff[3:0])) begin
               phase_in = PH_TAIL_GOOD;
            end else begin
               phase_in = PH_TAIL_BAD;
            end
         end
         default: begin
            verdict = 1'b1;
            if (b != TAIL_BYTE) begin
               code = ST_BAD_TAIL;
            end else if (phase_ff == PH_TAIL_BAD) begin
               code = ST_CHECKSUM;
            end else begin
               code = ST_OK;
            end
         end
      endcase

      // burst ended mid-frame: truncation overrides a forwarded byte
      if (taken && !verdict && item.end_of_buffer) begin
         verdict = 1'b1;
         code    = ST_TRUNCATED;
         forward = 1'b0;
      end
      if (verdict) begin
         phase_in = PH_HUNT;
         pos_in   = '0;
      end

      result.valid                  = verdict || forward;
      result.payload.kind           = verdict ? KIND_VERDICT : KIND_DATA;
      result.payload.data_byte      = forward ? b : 8'd0;
      result.payload.command        = cmd_in;
      result.payload.frame_type     = type_in;
      result.payload.channel        = chan_in;
      result.payload.payload_length = (len_in >= MIN_LENGTH) ? (len_in - MIN_LENGTH) : 8'd0;
      result.payload.status         = verdict ? code : ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= '0;
         len_ff   <= '0;
         type_ff  <= '0;
         chan_ff  <= '0;
         cmd_ff   <= '0;
         sum_ff   <= '0;
         hex1_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         type_ff  <= type_in;
         chan_ff  <= chan_in;
         cmd_ff   <= cmd_in;
         sum_ff   <= sum_in;
         hex1_ff  <= hex1_in;
      end
   end

`ifndef SYNTHESIS
   // a verdict always sends the machine back to hunting
   a_verdict_rehunt: assert property (@(posedge clock) disable iff (reset)
      advance && result.valid && result.payload.kind == KIND_VERDICT
      |=> phase_ff == PH_HUNT)
      else $error("parser did not return to hunt after verdict");

   // while hunting the position counter sits at zero
   a_hunt_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HUNT |-> pos_ff == 8'd0)
      else $error("position nonzero while hunting");

   // a forwarded byte only comes out of the payload section
   a_fwd_body: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.payload.kind == KIND_DATA |-> phase_ff == PH_BODY)
      else $error("data beat outside payload");
`endif

endmodule

[rtl/core/acfr_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfr_out_reg: result beat register
// Holds one response beat until the consumer takes it.
// ----------------------------------------------------------------------------
module acfr_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  acfr_pkg::result_type result,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output acfr_pkg::rsp_type    rsp_payload,
   output logic                 room
);
   import acfr_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type payload_ff, payload_in;

   // free now, or emptied at this edge
   assign room = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in   = valid_ff;
      payload_in = payload_ff;
      if (advance) begin
         valid_in   = result.valid;
         payload_in = result.payload;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      payload_ff <= payload_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule
